// File: src/cbm_pkg.sv
// shared types, codes and helpers for the cartridge bank mapper
`default_nettype none

package cbm_pkg;

	// item action codes
	typedef enum logic [1:0] {
		ACT_WRITE    = 2'd0,
		ACT_CPU_READ = 2'd1,
		ACT_PPU_READ = 2'd2
	} action_t;

	// result target codes
	typedef enum logic [1:0] {
		TGT_NONE   = 2'd0,
		TGT_PRG    = 2'd1,
		TGT_CHR    = 2'd2,
		TGT_NT_RAM = 2'd3
	} target_t;

	// configuration register indexes (byte address bits 3..2)
	localparam logic [1:0] REG_PRG_MASK   = 2'd0;
	localparam logic [1:0] REG_CHR_MASK   = 2'd1;
	localparam logic [1:0] REG_NT_MASK    = 2'd2;
	localparam logic [1:0] REG_HAS_CHR    = 2'd3;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// configuration reset values
	localparam logic [7:0] PRG_MASK_RST = 8'd7;
	localparam logic [7:0] CHR_MASK_RST = 8'd127;
	localparam logic [7:0] NT_MASK_RST  = 8'd255;
	localparam logic       HAS_CHR_RST  = 1'b1;

	// mapper register select, cpu address bits 14..12 with bit 15 set
	localparam logic [2:0] SEL_PAT0 = 3'd0;
	localparam logic [2:0] SEL_PAT1 = 3'd1;
	localparam logic [2:0] SEL_PAT2 = 3'd2;
	localparam logic [2:0] SEL_PAT3 = 3'd3;
	localparam logic [2:0] SEL_NT0  = 3'd4;
	localparam logic [2:0] SEL_NT1  = 3'd5;
	localparam logic [2:0] SEL_CTRL = 3'd6;
	localparam logic [2:0] SEL_PRG  = 3'd7;

	// nametable layout codes
	localparam logic [1:0] LAYOUT_VERT  = 2'd0;
	localparam logic [1:0] LAYOUT_HORZ  = 2'd1;
	localparam logic [1:0] LAYOUT_ONE_0 = 2'd2;
	localparam logic [1:0] LAYOUT_ONE_1 = 2'd3;

	// rom nametable banks have bit 7 forced before the config mask is applied
	localparam logic [7:0] NT_ROM_BIT = 8'h80;

	typedef struct packed {
		logic [7:0] prg_bank_mask;
		logic [7:0] pattern_bank_mask;
		logic [7:0] nametable_rom_mask;
		logic       has_pattern_rom;
	} cfg_t;

	typedef struct packed {
		logic [3:0][7:0] pattern_bank;
		logic [1:0][7:0] nametable_bank;
		logic [1:0]      layout_select;
		logic [1:0]      mirror_mode;
		logic            nametable_from_rom;
		logic [7:0]      prg_bank;
	} map_state_t;

	// which of the two physical pages a nametable lands on
	function automatic logic page_of(input logic [1:0] layout, input logic [1:0] tbl);
		logic pg;
		unique case (layout)
			LAYOUT_VERT:  pg = tbl[0];
			LAYOUT_HORZ:  pg = tbl[1];
			LAYOUT_ONE_0: pg = 1'b0;
			LAYOUT_ONE_1: pg = 1'b1;
			default:      pg = 1'b0;
		endcase
		return pg;
	endfunction

endpackage

`default_nettype wire

// File: src/cbm_in_if.sv
// input item channel: action, address, data
`default_nettype none

interface cbm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] address;
	logic [7:0]  data;

	modport source (output valid, action, address, data, input ready);
	modport sink   (input valid, action, address, data, output ready);
endinterface

`default_nettype wire

// File: src/cbm_out_if.sv
// result channel: target memory and byte offset
`default_nettype none

interface cbm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  target;
	logic [21:0] phys_address;

	modport source (output valid, target, phys_address, input ready);
	modport sink   (input valid, target, phys_address, output ready);
endinterface

`default_nettype wire

// File: src/cbm_regfile.sv
// apb configuration registers with read back
`default_nettype none

module cbm_regfile
	import cbm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_bank_mask      <= PRG_MASK_RST;
			cfg_q.pattern_bank_mask  <= CHR_MASK_RST;
			cfg_q.nametable_rom_mask <= NT_MASK_RST;
			cfg_q.has_pattern_rom    <= HAS_CHR_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRG_MASK: cfg_q.prg_bank_mask      <= pwdata[7:0];
				REG_CHR_MASK: cfg_q.pattern_bank_mask  <= pwdata[7:0];
				REG_NT_MASK:  cfg_q.nametable_rom_mask <= pwdata[7:0];
				REG_HAS_CHR:  cfg_q.has_pattern_rom    <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRG_MASK: prdata = {24'd0, cfg_q.prg_bank_mask};
			REG_CHR_MASK: prdata = {24'd0, cfg_q.pattern_bank_mask};
			REG_NT_MASK:  prdata = {24'd0, cfg_q.nametable_rom_mask};
			REG_HAS_CHR:  prdata = {31'd0, cfg_q.has_pattern_rom};
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/cbm_xlate.sv
// address translation for cpu and ppu reads
`default_nettype none

module cbm_xlate
	import cbm_pkg::*;
(
	input  wire logic [1:0]  action,
	input  wire logic [15:0] address,
	input  wire cfg_t        cfg,
	input  wire map_state_t  st,
	output logic [1:0]       target,
	output logic [21:0]      phys_address
);

	logic [7:0] prg_bank;
	logic [7:0] chr_bank;
	logic [7:0] nt_bank;
	logic       nt_sel;
	logic       ram_page;

	always_comb begin
		prg_bank = address[14] ? cfg.prg_bank_mask : (st.prg_bank & cfg.prg_bank_mask);
		chr_bank = st.pattern_bank[address[12:11]] & cfg.pattern_bank_mask;
		nt_sel   = page_of(st.layout_select, address[11:10]);
		nt_bank  = (st.nametable_bank[nt_sel] | NT_ROM_BIT) & cfg.nametable_rom_mask;
		ram_page = page_of(st.mirror_mode, address[11:10]);

		target       = TGT_NONE;
		phys_address = '0;
		unique case (action)
			ACT_WRITE: ;
			ACT_CPU_READ: begin
				if (address[15]) begin
					target       = TGT_PRG;
					phys_address = {prg_bank, address[13:0]};
				end
			end
			ACT_PPU_READ: begin
				// bits 15..14 ignored, 3000-3fff mirrors the nametable area
				if (!address[13]) begin
					target       = TGT_CHR;
					phys_address = {3'd0, chr_bank, address[10:0]};
				end else if (st.nametable_from_rom && cfg.has_pattern_rom) begin
					target       = TGT_CHR;
					phys_address = {4'd0, nt_bank, address[9:0]};
				end else begin
					target       = TGT_NT_RAM;
					phys_address = {11'd0, ram_page, address[9:0]};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: src/cartridge_bank_mapper_rom_nametables.sv
// top level of the cartridge bank mapper with rom nametables
//
//   channel  dir  kind         payload
//   in_ch    in   valid/ready  action[1:0] address[15:0] data[7:0]
//   out_ch   out  valid/ready  target[1:0] phys_address[21:0]
//   apb      in   psel/penable paddr[3:0] pwdata[31:0] prdata[31:0], pready tied high
//
// one beat in, one beat out; a beat can be taken every cycle while the result is not stalled
// a beat passes through the input register, then is translated into the result register
// mapper registers are written as a write beat leaves the input register, so a
// read beat right behind it already sees the new bank values
// a stalled result holds, and the input register still fills behind it
// arst_n clears the mapper registers and valid flags and loads config reset values
`default_nettype none

module cartridge_bank_mapper_rom_nametables
	import cbm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	cbm_in_if.sink                  in_ch,
	cbm_out_if.source               out_ch,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	cfg_t       cfg;
	map_state_t st_q;

	// input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// result register
	logic        out_valid_q;
	logic [1:0]  target_q;
	logic [21:0] phys_q;

	logic        in_acc;
	logic        adv;
	logic        do_write;
	logic [1:0]  xl_target;
	logic [21:0] xl_phys;

	cbm_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbm_xlate u_xlate (
		.action       (action_s1),
		.address      (address_s1),
		.cfg          (cfg),
		.st           (st_q),
		.target       (xl_target),
		.phys_address (xl_phys)
	);

	// result register moves when it is empty or being taken
	assign adv          = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || adv;
	assign in_acc       = in_ch.valid && in_ch.ready;
	// writes below 8000 are dropped
	assign do_write     = adv && valid_s1 && (action_s1 == ACT_WRITE) && address_s1[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1  <= in_ch.action;
			address_s1 <= in_ch.address;
			data_s1    <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			target_q <= xl_target;
			phys_q   <= xl_phys;
		end
	end

	// mapper register file, selected by cpu address bits 14..12
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (do_write) begin
			unique case (address_s1[14:12])
				SEL_PAT0, SEL_PAT1, SEL_PAT2, SEL_PAT3: begin
					st_q.pattern_bank[address_s1[13:12]] <= data_s1;
				end
				SEL_NT0: st_q.nametable_bank[0] <= data_s1;
				SEL_NT1: st_q.nametable_bank[1] <= data_s1;
				SEL_CTRL: begin
					st_q.layout_select      <= data_s1[1:0];
					st_q.nametable_from_rom <= data_s1[4];
					// ram layout only follows while rom nametables are off
					if (!data_s1[4]) begin
						st_q.mirror_mode <= data_s1[1:0];
					end
				end
				SEL_PRG: st_q.prg_bank <= data_s1;
				default: ;
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.target       = target_q;
	assign out_ch.phys_address = phys_q;

endmodule

`default_nettype wire

// File: src/cbm_checker.sv
// port level checks for the bank mapper, bound to the top level
`default_nettype none

module cbm_checker
	import cbm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_target,
	input wire logic [21:0] out_phys
);

	logic in_beat;
	assign in_beat = in_valid && in_ready;

	// a stalled result keeps its beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_target) && $stable(out_phys))
		else $error("result changed while stalled");

	// a fresh result comes from an input beat that passed through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_beat, 2))
		else $error("result without matching input beat");

	// nametable ram offsets stay inside two 1KB pages
	a_ram_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_target == TGT_NT_RAM) |-> (out_phys[21:11] == 11'd0))
		else $error("nametable ram offset out of range");

	// no target means a zero offset
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_target == TGT_NONE) |-> (out_phys == 22'd0))
		else $error("nonzero offset with no target");

endmodule

bind cartridge_bank_mapper_rom_nametables cbm_checker u_cbm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_target (out_ch.target),
	.out_phys   (out_ch.phys_address)
);

`default_nettype wire
